>>> sv/tptt_pkg.sv
package tptt_pkg;

    // Address split: page number in the upper byte, offset in the lower byte
    localparam int ADDR_W     = 16;
    localparam int OFFSET_W   = 8;
    localparam int PAGE_NUM_W = 8;
    localparam int FRAME_W    = 8;
    localparam int PAGE_SPAN  = 256;  // number of page codes in the address

    // Result flags on m_tuser, lowest bit up
    localparam int USER_W        = 2;
    localparam int USER_TLB_HIT  = 0;
    localparam int USER_FAULT    = 1;

    // TLB lookup answer
    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
    } tlb_result_t;

    // Page-table read answer
    typedef struct packed {
        logic               present;
        logic [FRAME_W-1:0] frame;
    } pt_result_t;

endpackage

>>> sv/tptt_tlb.sv
module tptt_tlb #(
    parameter int TLB_ENTRIES = 16,
    parameter int PG_W        = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [PG_W-1:0]            lookup_page,
    output tptt_pkg::tlb_result_t      lookup,
    input  logic                       fill_en,
    input  logic [PG_W-1:0]            fill_page,
    input  logic [tptt_pkg::FRAME_W-1:0] fill_frame
);
    import tptt_pkg::*;

    localparam int IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

    logic [TLB_ENTRIES-1:0] valid_reg;
    logic [PG_W-1:0]        tag_reg   [TLB_ENTRIES];
    logic [FRAME_W-1:0]     frame_reg [TLB_ENTRIES];
    logic [IDX_W-1:0]       ptr_reg;
    logic [IDX_W-1:0]       ptr_next;
    logic [TLB_ENTRIES-1:0] match;

    // Parallel tag compare; at most one entry matches, so an OR of the
    // masked frames picks it
    always_comb begin
        lookup.hit   = 1'b0;
        lookup.frame = '0;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            match[i]     = valid_reg[i] && (tag_reg[i] == lookup_page);
            lookup.hit   = lookup.hit | match[i];
            lookup.frame = lookup.frame | (frame_reg[i] & {FRAME_W{match[i]}});
        end
    end

    // Round-robin insert pointer
    always_comb begin
        if (ptr_reg == IDX_W'(TLB_ENTRIES - 1)) begin
            ptr_next = '0;
        end else begin
            ptr_next = ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            ptr_reg   <= '0;
        end else if (fill_en) begin
            valid_reg[ptr_reg] <= 1'b1;
            ptr_reg            <= ptr_next;
        end
    end

    // Entry payload
    always_ff @(posedge aclk) begin
        if (fill_en) begin
            tag_reg[ptr_reg]   <= fill_page;
            frame_reg[ptr_reg] <= fill_frame;
        end
    end

endmodule

>>> sv/tptt_page_table.sv
module tptt_page_table #(
    parameter int NUM_PAGES = 256,
    parameter int PG_W      = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         rd_en,
    input  logic [PG_W-1:0]              rd_addr,
    output tptt_pkg::pt_result_t         rd_data,
    input  logic                         wr_en,
    input  logic [PG_W-1:0]              wr_addr,
    input  logic [tptt_pkg::FRAME_W-1:0] wr_frame
);
    import tptt_pkg::*;

    logic [FRAME_W-1:0]   frame_mem [NUM_PAGES];
    logic [NUM_PAGES-1:0] present_reg;
    logic                 rd_present_reg;
    logic [FRAME_W-1:0]   rd_frame_reg;

    // Present bits clear at reset; frame store has no reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= '0;
        end else if (wr_en) begin
            present_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_present_reg <= present_reg[rd_addr];
        end
    end

    // Synchronous frame memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            frame_mem[wr_addr] <= wr_frame;
        end
        if (rd_en) begin
            rd_frame_reg <= frame_mem[rd_addr];
        end
    end

    assign rd_data.present = rd_present_reg;
    assign rd_data.frame   = rd_frame_reg;

endmodule

>>> sv/tlb_page_table_translator.sv
// Translates 16-bit logical addresses (page in the upper byte, offset in the
// lower byte) to physical addresses through a fully associative TLB backed by
// a page table. A transaction first reads the page-table memory (synchronous
// read), then compares the TLB tags, picks the frame, fills the TLB on a TLB
// miss and writes the page table on a fault. One address is in flight at a
// time; the next is accepted the cycle after the result is loaded into the
// output register, while that result waits for the consumer. A fault hands
// out the next frame from a counter that wraps at NUM_FRAMES; TLB fills go to
// a round-robin slot. tlb_hit and pt_fault are never both set.
module tlb_page_table_translator #(
    parameter int NUM_PAGES   = 256,
    parameter int NUM_FRAMES  = 256,
    parameter int TLB_ENTRIES = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [tptt_pkg::ADDR_W-1:0] s_tdata,   // [15:0] logical_addr
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [tptt_pkg::ADDR_W-1:0] m_tdata,   // [15:0] physical_addr
    output logic [tptt_pkg::USER_W-1:0] m_tuser    // [0] tlb_hit, [1] pt_fault
);
    import tptt_pkg::*;

    localparam int PG_W = $clog2(NUM_PAGES);
    localparam int FR_W = $clog2(NUM_FRAMES);

    typedef enum logic {
        ST_IDLE,
        ST_RESOLVE
    } state_t;

    state_t                state_reg;
    logic [PG_W-1:0]       page_reg;
    logic [OFFSET_W-1:0]   offset_reg;
    logic [FR_W-1:0]       frame_ctr_reg;
    logic [FR_W-1:0]       frame_ctr_next;
    logic                  m_valid_reg;
    logic [ADDR_W-1:0]     m_data_reg;
    logic [USER_W-1:0]     m_user_reg;

    logic [PG_W-1:0]       wrap_tbl [PAGE_SPAN];
    logic [PG_W-1:0]       in_page;
    logic                  in_accept;
    logic                  out_free;
    logic                  resolve;
    logic                  fault;
    logic [FRAME_W-1:0]    frame_sel;
    logic [FRAME_W-1:0]    new_frame;
    tlb_result_t           tlb_res;
    pt_result_t            pt_res;

    // Page number folded into the table range
    for (genvar g = 0; g < PAGE_SPAN; g++) begin : g_wrap
        assign wrap_tbl[g] = PG_W'(g % NUM_PAGES);
    end
    assign in_page = wrap_tbl[s_tdata[ADDR_W-1:OFFSET_W]];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign resolve   = (state_reg == ST_RESOLVE) && out_free;

    // Frame selection: TLB, then page table, else a fresh frame
    assign new_frame = FRAME_W'(frame_ctr_reg);
    assign fault     = !tlb_res.hit && !pt_res.present;
    always_comb begin
        priority if (tlb_res.hit) begin
            frame_sel = tlb_res.frame;
        end else if (pt_res.present) begin
            frame_sel = pt_res.frame;
        end else begin
            frame_sel = new_frame;
        end
    end

    always_comb begin
        if (frame_ctr_reg == FR_W'(NUM_FRAMES - 1)) begin
            frame_ctr_next = '0;
        end else begin
            frame_ctr_next = frame_ctr_reg + 1'b1;
        end
    end

    tptt_tlb #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .PG_W        (PG_W)
    ) u_tlb (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .lookup_page (page_reg),
        .lookup      (tlb_res),
        .fill_en     (resolve && !tlb_res.hit),
        .fill_page   (page_reg),
        .fill_frame  (frame_sel)
    );

    tptt_page_table #(
        .NUM_PAGES (NUM_PAGES),
        .PG_W      (PG_W)
    ) u_page_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (in_accept),
        .rd_addr   (in_page),
        .rd_data   (pt_res),
        .wr_en     (resolve && fault),
        .wr_addr   (page_reg),
        .wr_frame  (new_frame)
    );

    // Control: state, frame counter, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            frame_ctr_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        state_reg <= ST_RESOLVE;
                    end
                end
                ST_RESOLVE: begin
                    if (resolve) begin
                        state_reg <= ST_IDLE;
                        if (fault) begin
                            frame_ctr_reg <= frame_ctr_next;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            // New result loads the output; otherwise it drains when taken
            if (resolve) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            page_reg   <= in_page;
            offset_reg <= s_tdata[OFFSET_W-1:0];
        end
        if (resolve) begin
            m_data_reg               <= {frame_sel, offset_reg};
            m_user_reg[USER_TLB_HIT] <= tlb_res.hit;
            m_user_reg[USER_FAULT]   <= fault;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
